// ===== rtl/sbs_pkg.sv =====
// Shared constants and controller/datapath types for the sorted-table search block.
`default_nettype none

package sbs_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH) + 1;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned IN_DATA_W   = ((IDX_W + KEY_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = ((IDX_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } sbs_cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;     // write table entry from input transfer
    logic start;     // load bounds and key for a new search
    logic probe;     // latch midpoint and read its entry
    logic step_lo;   // entry below key: move low bound past midpoint
    logic step_hi;   // entry above key: move high bound below midpoint
    logic miss;      // bounds crossed: record not found
    logic hit;       // entry equals key: record midpoint
    logic load_out;  // move result into the output register
  } sbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bounds_open;
    logic key_eq;
    logic key_lt;
  } sbs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sbs_datapath.sv =====
// Datapath: table memory, search bounds, key compare and output register.
`default_nettype none

module sbs_datapath import sbs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CNT_W-1:0]      cfg_wdata_i,
  input  wire logic [IDX_W-1:0]      wr_idx_i,
  input  wire logic [KEY_W-1:0]      key_i,
  input  wire sbs_cmd_t              cmd_i,
  output sbs_stat_t                  stat_o,
  output logic                       found_o,
  output logic [OUT_DATA_W-1:0]      data_o
);

  logic [KEY_W-1:0] mem_q [TABLE_DEPTH];
  logic [KEY_W-1:0] rdata_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] entry_count_q;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hip_q, hip_d;
  logic [IDX_W-1:0] mid_q;
  logic [IDX_W-1:0] mid;
  logic [CNT_W-1:0] count_clamp;
  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] mid_full;
  logic             res_found_q;
  logic [IDX_W-1:0] res_pos_q;
  logic             out_found_q;
  logic [IDX_W-1:0] out_pos_q;

  assign count_clamp = (entry_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : entry_count_q;
  // hip_q holds high bound plus one; only used while lo_q < hip_q
  assign span     = hip_q - CNT_W'(1) - lo_q;
  assign mid_full = lo_q + (span >> 1);
  assign mid      = mid_full[IDX_W-1:0];

  assign stat_o.bounds_open = (lo_q < hip_q);
  assign stat_o.key_eq      = (rdata_q == key_q);
  assign stat_o.key_lt      = ($signed(rdata_q) < $signed(key_q));

  always_comb begin
    lo_d  = lo_q;
    hip_d = hip_q;
    if (cmd_i.start) begin
      lo_d  = '0;
      hip_d = count_clamp;
    end else if (cmd_i.step_lo) begin
      lo_d  = {1'b0, mid_q} + CNT_W'(1);
    end else if (cmd_i.step_hi) begin
      hip_d = {1'b0, mid_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= CNT_W'(TABLE_DEPTH);
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_idx_i] <= key_i;
    end
    if (cmd_i.probe) begin
      rdata_q <= mem_q[mid];
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hip_q <= hip_d;
    if (cmd_i.start) begin
      key_q <= key_i;
    end
    if (cmd_i.probe) begin
      mid_q <= mid;
    end
    if (cmd_i.miss) begin
      res_found_q <= 1'b0;
      res_pos_q   <= '0;
    end else if (cmd_i.hit) begin
      res_found_q <= 1'b1;
      res_pos_q   <= mid_q;
    end
    if (cmd_i.load_out) begin
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
    end
  end

  assign found_o = out_found_q;
  assign data_o  = {{(OUT_DATA_W - IDX_W){1'b0}}, out_pos_q};

endmodule

`default_nettype wire

// ===== rtl/sbs_ctrl.sv =====
// Controller: accepts transfers, sequences probes and owns the output valid.
`default_nettype none

module sbs_ctrl import sbs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_kind_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire sbs_stat_t stat_i,
  output sbs_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == CMD_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = S_PROBE;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (stat_i.bounds_open) begin
          cmd_o.probe = 1'b1;
          state_d     = S_CMP;
        end else begin
          cmd_o.miss = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_CMP: begin
        if (stat_i.key_eq) begin
          cmd_o.hit = 1'b1;
          state_d   = S_DONE;
        end else begin
          cmd_o.step_lo = stat_i.key_lt;
          cmd_o.step_hi = ~stat_i.key_lt;
          state_d       = S_PROBE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_table_binary_search_top.sv =====
// Top level of the sorted-table binary search block.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         tvalid / tready           tuser: command; tdata: entry_index, key_value
//  m_axis    out        tvalid / tready           tuser: found; tdata: position
//  cfg       in         cfg_we_i (no wait)        cfg_wdata_i: entry_count
//
// A write keeps the block in its idle state; the next transfer can follow right away.
// A search, after the accept state, alternates a memory read and a compare for each
// probe through one shared read port, then does a final bounds check on a miss and
// the result load. The result waits in the output register while the next item
// is taken; a search whose result finds that register still full holds in its
// last state and stalls the input.
// Reset leaves the table contents undefined; entry_count returns to 1024.
`default_nettype none

module sorted_table_binary_search_top import sbs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic                  s_axis_tuser_i,   // [0] command
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [9:0] entry_index, [41:10] key_value
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic                       m_axis_tuser_o,   // [0] found
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,   // [9:0] position
  input  wire logic                  cfg_we_i,
  input  wire logic [CNT_W-1:0]      cfg_wdata_i
);

  sbs_cmd_t  cmd;
  sbs_stat_t stat;

  sbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_kind_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_idx_i    (s_axis_tdata_i[IDX_W-1:0]),
    .key_i       (s_axis_tdata_i[IDX_W+KEY_W-1:IDX_W]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .found_o     (m_axis_tuser_o),
    .data_o      (m_axis_tdata_o)
  );

  // a miss always reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("miss result with nonzero position");

  // a search transfer blocks the input while probing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == CMD_SEARCH)
      |=> !s_axis_tready_o)
    else $error("input ready during search");

  // a write transfer leaves the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == CMD_WRITE)
      |=> s_axis_tready_o)
    else $error("input stalled after table write");

endmodule

`default_nettype wire

// ===== tb/sorted_table_binary_search_top_tb.sv =====
// Testbench for the sorted-table binary search block: stream stimulus and scoreboard check.
`timescale 1ns / 1ps

module sorted_table_binary_search_top_tb;
  import sbs_pkg::*;

  localparam int unsigned RUN_LIMIT     = 1000000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } answer_t;

  // Mirror of the table and entry_count; predicts one answer per search transfer.
  class search_board;
    logic [KEY_W-1:0] entries [TABLE_DEPTH];
    logic [CNT_W-1:0] span;
    answer_t          pending_answers[$];
    int unsigned      mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      span = CNT_W'(TABLE_DEPTH);
      mismatches = 0;
    endfunction

    function void set_span(logic [CNT_W-1:0] v);
      span = v;
    endfunction

    function int unsigned span_limit();
      return (span > TABLE_DEPTH) ? TABLE_DEPTH : int'(span);
    endfunction

    function int unsigned pending();
      return pending_answers.size();
    endfunction

    // Probe midpoints until a match or until the bounds cross.
    function answer_t locate_key(logic [KEY_W-1:0] key);
      int unsigned lo, hi_plus, mid;
      answer_t     a;
      a = '0;
      lo = 0;
      hi_plus = span_limit();
      while (lo < hi_plus && !a.found) begin
        mid = lo + ((hi_plus - 1 - lo) >> 1);
        if (entries[mid] == key) begin
          a.found = 1'b1;
          a.position = mid[IDX_W-1:0];
        end else if ($signed(entries[mid]) < $signed(key)) begin
          lo = mid + 1;
        end else begin
          hi_plus = mid;
        end
      end
      return a;
    endfunction

    function void note_transfer(sbs_cmd_e cmd, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key);
      if (cmd == CMD_WRITE) entries[idx] = key;
      else pending_answers.push_back(locate_key(key));
    endfunction

    function void check_answer(logic found, logic [IDX_W-1:0] position);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $error("unexpected result: found %0d position %0d", found, position);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        mismatches++;
      end
      if (position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, position);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic                  s_axis_tuser_i = 1'b0;   // [0] command
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;     // [9:0] entry_index, [41:10] key_value
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic                  m_axis_tuser_o;          // [0] found
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;          // [9:0] position
  logic                  cfg_we_i = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i = '0;

  search_board sb;
  int unsigned burst_left = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned epoch_left = 0;
  int unsigned stall_mode = 0;
  int unsigned cycle_count = 0;

  sorted_table_binary_search_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("sorted_table_binary_search_top_tb: FAIL");
      $finish;
    end
  end

  // Result side: check each transfer, stall on changing patterns, one long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_answer(m_axis_tuser_o, m_axis_tdata_o[IDX_W-1:0]);
        results_seen++;
        if (results_seen == 30) hold_left = 400;
      end
      if (epoch_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        epoch_left = $urandom_range(20, 80);
      end else begin
        epoch_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready_i <= ($urandom_range(0, 1) != 0);
          default: m_axis_tready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until the transfer; valid stays high afterward.
  task automatic send_item(sbs_cmd_e cmd, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{(IN_DATA_W - IDX_W - KEY_W){1'b0}}, key, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_transfer(cmd, idx, key);
  endtask

  // Bursts of random length separated by random gaps, some longer than a search.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic search(logic [KEY_W-1:0] key);
    send_item(CMD_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), key);
    pace();
  endtask

  task automatic write_entry(logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key);
    send_item(CMD_WRITE, idx, key);
    pace();
  endtask

  // Wait out every pending answer plus the block's search latency.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_span(int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[CNT_W-1:0];
    sb.set_span(v[CNT_W-1:0]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Ascending keys from the most negative to the most positive, with a run of duplicates.
  task automatic load_table();
    longint acc;
    int unsigned stride;
    acc = -64'sd2147483648;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 400 || i == 401 || $urandom_range(0, 15) == 0) stride = 0;
      else stride = $urandom_range(0, 6291456);
      if (i > 0) acc += stride;
      if (acc > 64'sd2147483647 || i == TABLE_DEPTH - 1) acc = 64'sd2147483647;
      write_entry(IDX_W'(i), acc[KEY_W-1:0]);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned lim, sel, r;
    logic [KEY_W-1:0] k;
    lim = sb.span_limit();
    sel = $urandom_range(0, 99);
    r = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
    if (sel < 50 && lim > 0) begin
      k = sb.entries[r];
    end else if (sel < 70 && lim > 0) begin
      k = sb.entries[r] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
    end else if (sel < 80) begin
      case ($urandom_range(0, 3))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        2: k = '0;
        default: k = '1;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // Mostly a value between the neighbors, so the table stays sorted; else anything.
  function automatic logic [KEY_W-1:0] pick_entry_value(int unsigned idx);
    longint lo_v, hi_v;
    lo_v = (idx == 0) ? -64'sd2147483648 : longint'($signed(sb.entries[idx - 1]));
    hi_v = (idx == TABLE_DEPTH - 1) ? 64'sd2147483647 : longint'($signed(sb.entries[idx + 1]));
    if ($urandom_range(0, 4) == 0 || lo_v > hi_v) return $urandom;
    lo_v = lo_v + (longint'($urandom) % (hi_v - lo_v + 1));
    return lo_v[KEY_W-1:0];
  endfunction

  task automatic run_random(int unsigned n);
    int unsigned lim, idx;
    repeat (n) begin
      if ($urandom_range(0, 99) < 20) begin
        lim = sb.span_limit();
        if (lim > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, lim - 1);
        else idx = $urandom_range(0, TABLE_DEPTH - 1);
        write_entry(IDX_W'(idx), pick_entry_value(idx));
      end else begin
        search(pick_key());
      end
    end
  endtask

  initial begin
    int unsigned span_plan[10];
    logic [KEY_W-1:0] saved;
    sb = new();
    span_plan = '{0, 1, 2, 3, 1023, 1025, 2047, 1024, 0, 0};
    span_plan[8] = $urandom_range(4, 1024);
    span_plan[9] = $urandom_range(0, 2047);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_table();

    // Directed searches on the full table at the reset entry_count.
    search(KEY_MIN);
    search(KEY_MAX);
    search(sb.entries[0]);
    search(sb.entries[TABLE_DEPTH - 1]);
    search(sb.entries[511]);
    search(sb.entries[512]);
    search(sb.entries[400]);
    search(sb.entries[300] + 32'd1);
    search('0);
    search('1);
    // Break the ordering in one place, search through it, then restore it.
    saved = sb.entries[700];
    write_entry(IDX_W'(700), KEY_MIN);
    search(KEY_MIN);
    search(saved);
    write_entry(IDX_W'(700), saved);
    run_random(55);

    foreach (span_plan[p]) begin
      drain();
      write_span(span_plan[p]);
      if (span_plan[p] == 0) begin
        search(KEY_MIN);
        search(sb.entries[0]);
      end else if (span_plan[p] == 2047) begin
        search(sb.entries[TABLE_DEPTH - 1]);
        search(KEY_MAX);
      end
      run_random(50);
    end
    drain();

    if (sb.mismatches == 0) begin
      $display("sorted_table_binary_search_top_tb: PASS");
    end else begin
      $display("sorted_table_binary_search_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sbs_pkg.sv
rtl/sbs_datapath.sv
rtl/sbs_ctrl.sv
rtl/sorted_table_binary_search_top.sv
tb/sorted_table_binary_search_top_tb.sv
